>>> sv/ccam_pkg.sv
// types, constants and class helpers shared by the affix matcher modules
// no dependencies
package ccam_pkg;

  localparam int unsigned MaxPosDefault = 16;
  localparam int unsigned LetterCnt     = 52;
  localparam int unsigned ClassW        = LetterCnt + 1;

  localparam logic [7:0] CharOpen  = 8'h5B;
  localparam logic [7:0] CharClose = 8'h5D;
  localparam logic [7:0] CharCaret = 8'h5E;

  localparam logic KindPattern = 1'b0;
  localparam logic KindWord    = 1'b1;
  localparam logic FuncPattern = 1'b0;
  localparam logic FuncWord    = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_OPEN,
    PH_IN,
    PH_NEG
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT,
    ST_WORD,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic       func;
    logic [7:0] char_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic       ok;
    logic [4:0] position_count;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic pat_exec;
    logic word_exec;
    logic walk_issue;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_last;
    logic need_walk;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  // upper case maps to 0..25, lower case to 26..51
  function automatic logic [5:0] letter_idx(input logic [7:0] b);
    logic [7:0] d;
    d = b[5] ? (b - 8'h61 + 8'd26) : (b - 8'h41);
    return d[5:0];
  endfunction

  function automatic logic [LetterCnt-1:0] letter_bit(input logic [7:0] b);
    return LetterCnt'(1) << letter_idx(b);
  endfunction

  // class entry: negate flag on top, letter mask below
  function automatic logic class_hit(input logic [ClassW-1:0] e, input logic [7:0] b);
    logic hit;
    hit = is_letter(b) && e[letter_idx(b)];
    return hit ^ e[ClassW-1];
  endfunction

endpackage

>>> sv/ccam_ctrl.sv
// sequencer for the affix matcher: accept, parse or test, suffix walk, hand-off
// depends on ccam_pkg
module ccam_ctrl import ccam_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_func_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_func_i == FuncWord) ? ST_WORD : ST_PAT;
        end
      end
      ST_PAT: begin
        state_d = stat_i.item_last ? ST_RESULT : ST_IDLE;
      end
      ST_WORD: begin
        if (!stat_i.item_last) begin
          state_d = ST_IDLE;
        end else if (stat_i.need_walk) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_WALK: begin
        if (stat_i.walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_PAT: begin
        cmd_o.pat_exec = 1'b1;
      end
      ST_WORD: begin
        cmd_o.word_exec = 1'b1;
      end
      ST_WALK: begin
        cmd_o.walk_issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_RESULT: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> sv/ccam_dp.sv
// datapath: pattern parser, class memory, word tail shift line, verdict and output register
// depends on ccam_pkg
module ccam_dp import ccam_pkg::*; #(
  parameter int unsigned MAX_POS = MaxPosDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam int unsigned PCW = $clog2(MAX_POS + 1);
  localparam int unsigned IW  = (MAX_POS > 1) ? $clog2(MAX_POS) : 1;

  logic [ClassW-1:0] mem_q [MAX_POS];
  logic [ClassW-1:0] rdata_q;
  logic [7:0]        tail_q [MAX_POS];

  in_word_t          item_q;
  logic [PCW-1:0]    pos_q, pos_d, pos_eff, pos_m1, pos_eff_m1;
  phase_e            phase_q, phase_d, phase_eff;
  logic              bad_q, bad_d, bad_eff;
  logic              in_pat_q, in_pat_d;
  logic [PCW-1:0]    wl_q, wl_d, wl_inc;
  logic              prefix_q, prefix_d;
  logic              suffix_q;
  logic [ClassW-1:0] cls_q, cls_d;
  logic [PCW-1:0]    p_q, p_d, tail_sel;
  logic [7:0]        tb_q;
  logic              cmp_v_q;
  out_word_t         res_q, res_d;
  logic              out_valid_q;
  out_word_t         out_q;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [IW-1:0]     mem_raddr;
  logic [ClassW-1:0] mem_wdata;
  logic              need_walk;
  logic              ok_base;
  logic              pos_full;
  logic [7:0]        b;

  assign b          = item_q.char_byte;
  assign pos_eff    = in_pat_q ? pos_q : '0;
  assign phase_eff  = in_pat_q ? phase_q : PH_WAIT;
  assign bad_eff    = in_pat_q ? bad_q : 1'b0;
  assign pos_full   = (pos_eff >= PCW'(MAX_POS));
  assign pos_m1     = pos_q - 1'b1;
  assign pos_eff_m1 = pos_eff - 1'b1;
  assign wl_inc     = (wl_q >= PCW'(MAX_POS)) ? wl_q : wl_q + 1'b1;
  assign tail_sel   = pos_m1 - p_q;
  assign mem_raddr  = cmd_i.walk_issue ? p_q[IW-1:0] : wl_q[IW-1:0];

  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    bad_d     = bad_q;
    in_pat_d  = in_pat_q;
    wl_d      = wl_q;
    prefix_d  = prefix_q;
    cls_d     = cls_q;
    p_d       = p_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = pos_eff[IW-1:0];
    mem_wdata = {1'b0, letter_bit(b)};
    need_walk = 1'b0;
    ok_base   = 1'b0;

    if (cmd_i.pat_exec) begin
      // first byte after an ended pattern starts a fresh one
      pos_d    = pos_eff;
      phase_d  = phase_eff;
      bad_d    = bad_eff;
      in_pat_d = 1'b1;
      wl_d     = '0;
      prefix_d = 1'b1;
      if (!bad_eff) begin
        case (phase_eff)
          PH_WAIT: begin
            if (is_letter(b)) begin
              if (pos_full) begin
                bad_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                pos_d  = pos_eff + 1'b1;
              end
            end else if (b == CharOpen) begin
              if (pos_full) begin
                bad_d = 1'b1;
              end else begin
                pos_d   = pos_eff + 1'b1;
                phase_d = PH_OPEN;
                cls_d   = '0;
              end
            end else begin
              bad_d = 1'b1;
            end
          end
          PH_OPEN: begin
            if (b == CharCaret) begin
              cls_d[ClassW-1] = 1'b1;
              phase_d         = PH_NEG;
            end else if (is_letter(b)) begin
              cls_d   = cls_q | {1'b0, letter_bit(b)};
              phase_d = PH_IN;
            end else begin
              bad_d = 1'b1;
            end
          end
          default: begin
            if (is_letter(b)) begin
              cls_d = cls_q | {1'b0, letter_bit(b)};
            end else if (b == CharClose) begin
              // class is complete, commit it to its position
              mem_we    = 1'b1;
              mem_waddr = pos_eff_m1[IW-1:0];
              mem_wdata = cls_q;
              phase_d   = PH_WAIT;
            end else begin
              bad_d = 1'b1;
            end
          end
        endcase
      end
      if (item_q.last) begin
        if (phase_d != PH_WAIT) begin
          bad_d = 1'b1;
        end
        phase_d                = PH_WAIT;
        in_pat_d               = 1'b0;
        res_d.result_kind      = KindPattern;
        res_d.ok               = !bad_d;
        res_d.position_count   = 5'(pos_d);
      end
    end

    if (cmd_i.word_exec) begin
      // a word byte abandons an unfinished pattern
      if (in_pat_q) begin
        in_pat_d = 1'b0;
        bad_d    = 1'b1;
        phase_d  = PH_WAIT;
      end
      if ((wl_q < pos_q) && !class_hit(rdata_q, b)) begin
        prefix_d = 1'b0;
      end
      wl_d = wl_inc;
      if (item_q.last) begin
        ok_base              = !bad_d && (wl_inc >= pos_q);
        res_d.result_kind    = KindWord;
        res_d.position_count = 5'(pos_q);
        if (suffix_q) begin
          res_d.ok  = ok_base;
          need_walk = ok_base && (pos_q != '0);
        end else begin
          res_d.ok = ok_base && prefix_d;
        end
        p_d      = '0;
        wl_d     = '0;
        prefix_d = 1'b1;
      end
    end

    if (cmd_i.walk_issue) begin
      p_d = p_q + 1'b1;
    end
    // suffix walk: verdict accumulates one position per cycle
    if (cmp_v_q) begin
      res_d.ok = res_q.ok & class_hit(rdata_q, tb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_WAIT;
      bad_q       <= 1'b1;
      in_pat_q    <= 1'b0;
      wl_q        <= '0;
      prefix_q    <= 1'b1;
      suffix_q    <= 1'b0;
      p_q         <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      bad_q    <= bad_d;
      in_pat_q <= in_pat_d;
      wl_q     <= wl_d;
      prefix_q <= prefix_d;
      p_q      <= p_d;
      cmp_v_q  <= cmd_i.walk_issue;
      if (cfg_we_i) begin
        suffix_q <= cfg_wdata_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    cls_q <= cls_d;
    res_q <= res_d;
    if (cmd_i.walk_issue) begin
      tb_q <= tail_q[tail_sel[IW-1:0]];
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
    if (cmd_i.word_exec) begin
      tail_q[0] <= b;
      for (int i = 1; i < MAX_POS; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
    end
  end

  // class memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign stat_o.item_last = item_q.last;
  assign stat_o.need_walk = need_walk;
  assign stat_o.walk_last = (p_q == pos_m1);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/char_class_affix_matcher_top.sv
// top level of the character class affix matcher
// depends on ccam_pkg, ccam_ctrl and ccam_dp
//
//   port group   direction   handshake               payload
//   in           to block    in_valid_i / in_stall_o   in_data_i (in_word_t)
//   out          from block  out_valid_o / out_stall_i out_data_o (out_word_t)
//   cfg          to block    cfg_we_i                  cfg_wdata_i (match_suffix)
//
// a pattern or word byte is first accepted, then parsed or class tested
// the ending byte then adds a hand-off into the output register
// in suffix mode an ending byte on a valid pattern, with the word long enough,
// adds a suffix walk and a drain step, one class memory read per position
// reset gives an invalid pattern; class memory and word tail need no clearing
// a word waits in the output register while the next bytes are taken; an ending
// byte holds until that word is gone
module char_class_affix_matcher_top import ccam_pkg::*; #(
  parameter int unsigned MAX_POS = MaxPosDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ccam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ccam_dp #(
    .MAX_POS (MAX_POS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
